/* sv/c2s_pkg.sv */
// Package: shared defaults, arctangent table, division helper and CORDIC inverse-gain function for the c2s core.
package c2s_pkg;

    localparam int C2S_STAGES  = 16;
    localparam int C2S_COORD_W = 24;
    localparam int C2S_ANGLE_W = 16;

    // atan(2^-i), 2^32 per turn, rounded to nearest
    localparam logic [31:0] C2S_ATAN [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // restoring division, elaboration only
    function automatic logic [63:0] c2s_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 1/K in Q31 for n micro-rotations
    function automatic logic [31:0] c2s_inv_gain(input int n);
        logic [63:0] c;
        logic [63:0] d;
        logic [63:0] res;
        logic [63:0] bt;
        c = 64'd1 << 62;
        for (int i = 0; i < n && i < 32; i++) begin
            d = (64'd1 << (2 * i)) + 64'd1;
            c = c - c2s_udiv(c, d);
        end
        res = '0;
        bt  = 64'd1 << 62;
        while (bt > c) bt = bt >> 2;
        while (bt != 0) begin
            if (c >= res + bt) begin
                c   = c - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res[31:0];
    endfunction

endpackage

/* sv/cartesian_to_spherical_core.sv */
// Cartesian to spherical conversion core: two cascaded pipelined CORDIC vectoring units.
// Pipeline stages: input prep, CORDIC_STAGES azimuth stages, two gain-multiply stages,
//   CORDIC_STAGES elevation stages, two gain-multiply stages with saturation.
// Throughput: one item per cycle; the whole pipe freezes while an output item is stalled.
// Reset: synchronous active-low i_rst_n clears all valid bits; payload is not reset.
module cartesian_to_spherical_core import c2s_pkg::*; #(
    parameter int CORDIC_STAGES = C2S_STAGES,
    parameter int COORD_WIDTH   = C2S_COORD_W,
    parameter int ANGLE_WIDTH   = C2S_ANGLE_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [COORD_WIDTH-1:0] i_y_coord,
    input  logic signed [COORD_WIDTH-1:0] i_z_coord,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic        [COORD_WIDTH-1:0] o_radius,
    output logic signed [ANGLE_WIDTH-1:0] o_azimuth_angle,
    output logic signed [ANGLE_WIDTH-1:0] o_elevation_angle,
    output logic                          o_zero_vector
);

    localparam int N  = CORDIC_STAGES;
    localparam int CW = COORD_WIDTH;
    // guard bits below the input LSB
    localparam int G  = ((60 - CW) < 16) ? (60 - CW) : 16;
    // datapath width: scaled input plus headroom for CORDIC gain and sqrt(3)
    localparam int W  = CW + G + 3;
    // split point for the gain multiply: a low part of H bits and a high part of W-H bits
    localparam int H  = (W + 1) / 2;
    localparam int PW = W + 33;
    // pipeline depth
    localparam int T  = 2 * N + 5;
    localparam logic [31:0] INVK = c2s_inv_gain(N);
    localparam logic [31:0] ARND = 32'((64'd1 << (32 - ANGLE_WIDTH)) >> 1);
    localparam logic [PW-1:0] RND1 = PW'(64'd1 << 30);
    localparam logic [PW-1:0] RND2 = PW'(64'd1 << (30 + G));

    // whole pipe advances unless the output item is held
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic [T-1:0] r_vld;
    logic [T-1:0] r_zf;   // zero vector
    logic [T-2:0] r_xz;   // x and y both zero

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[T-2:0], i_valid};
        end
    end

    // ---- input prep: scale, fold negative x into the right half plane ----
    logic signed [CW+G-1:0] xs_in, ys_in, zs_in;
    logic signed [W-1:0]    xe, ye;
    logic                   xneg;
    assign xs_in = {i_x_coord, {G{1'b0}}};
    assign ys_in = {i_y_coord, {G{1'b0}}};
    assign zs_in = {i_z_coord, {G{1'b0}}};
    assign xe    = W'(xs_in);
    assign ye    = W'(ys_in);
    assign xneg  = i_x_coord[CW-1];

    // azimuth CORDIC state, index k is the input of micro-rotation k
    logic signed [W-1:0] r_x1 [0:N];
    logic signed [W-1:0] r_y1 [0:N];
    logic        [31:0]  r_a1 [0:N];
    // z rides along through azimuth CORDIC and its gain multiply
    logic signed [W-1:0] r_zc [0:N+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1[0] <= xneg ? -xe : xe;
            r_y1[0] <= xneg ? -ye : ye;
            r_a1[0] <= xneg ? 32'h8000_0000 : 32'd0;
            r_zc[0] <= W'(zs_in);
            r_zf    <= {r_zf[T-2:0], (i_x_coord == '0) && (i_y_coord == '0)
                                     && (i_z_coord == '0)};
            r_xz    <= {r_xz[T-3:0], (i_x_coord == '0) && (i_y_coord == '0)};
        end
    end

    // ---- azimuth CORDIC: one micro-rotation per stage ----
    for (genvar k = 0; k < N; k++) begin : g_az
        logic signed [W-1:0] xsh, ysh;
        assign xsh = r_x1[k] >>> k;
        assign ysh = r_y1[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_y1[k][W-1]) begin
                    r_x1[k+1] <= r_x1[k] + ysh;
                    r_y1[k+1] <= r_y1[k] - xsh;
                    r_a1[k+1] <= r_a1[k] + C2S_ATAN[k];
                end else begin
                    r_x1[k+1] <= r_x1[k] - ysh;
                    r_y1[k+1] <= r_y1[k] + xsh;
                    r_a1[k+1] <= r_a1[k] - C2S_ATAN[k];
                end
                r_zc[k+1] <= r_zc[k];
            end
        end
    end

    // ---- gain correction of the xy magnitude: split multiply, then sum ----
    logic [H+31:0]   r_pl1;
    logic [W-H+31:0] r_ph1;
    logic [31:0]     r_am1;
    logic [PW-1:0]   sum1;

    assign sum1 = (PW'(r_ph1) << H) + PW'(r_pl1) + RND1;

    // elevation CORDIC state
    logic signed [W-1:0] r_x2 [0:N];
    logic signed [W-1:0] r_y2 [0:N];
    logic        [31:0]  r_a2 [0:N];
    // azimuth rides along through elevation CORDIC and its first multiply stage
    logic        [31:0]  r_azc [0:N+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl1     <= r_x1[N][H-1:0] * INVK;
            r_ph1     <= r_x1[N][W-1:H] * INVK;
            r_am1     <= r_a1[N];
            r_zc[N+1] <= r_zc[N];
            // x stays non-negative, so the rounded product fits W bits
            r_x2[0]   <= signed'(sum1[W+30:31]);
            r_y2[0]   <= r_zc[N+1];
            r_a2[0]   <= 32'd0;
            r_azc[0]  <= r_am1;
        end
    end

    // ---- elevation CORDIC ----
    for (genvar k = 0; k < N; k++) begin : g_el
        logic signed [W-1:0] xsh, ysh;
        assign xsh = r_x2[k] >>> k;
        assign ysh = r_y2[k] >>> k;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_y2[k][W-1]) begin
                    r_x2[k+1] <= r_x2[k] + ysh;
                    r_y2[k+1] <= r_y2[k] - xsh;
                    r_a2[k+1] <= r_a2[k] + C2S_ATAN[k];
                end else begin
                    r_x2[k+1] <= r_x2[k] - ysh;
                    r_y2[k+1] <= r_y2[k] + xsh;
                    r_a2[k+1] <= r_a2[k] - C2S_ATAN[k];
                end
                r_azc[k+1] <= r_azc[k];
            end
        end
    end

    // ---- gain correction of the length, rounding to input unit, outputs ----
    logic [H+31:0]   r_pl2;
    logic [W-H+31:0] r_ph2;
    logic [31:0]     r_el2;
    logic [PW-1:0]   sum2;
    logic [CW+3:0]   rad_full;
    logic [31:0]     az_rnd, el_rnd;

    assign sum2     = (PW'(r_ph2) << H) + PW'(r_pl2) + RND2;
    assign rad_full = sum2[W+31:31+G];
    assign az_rnd   = r_azc[N+1] + ARND;
    assign el_rnd   = r_el2 + ARND;

    logic [CW-1:0]          r_rad;
    logic [ANGLE_WIDTH-1:0] r_az, r_el;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl2      <= r_x2[N][H-1:0] * INVK;
            r_ph2      <= r_x2[N][W-1:H] * INVK;
            r_el2      <= r_a2[N];
            r_azc[N+1] <= r_azc[N];
            // zero for the zero vector, else saturate on overflow past COORD_WIDTH bits
            if (r_zf[T-2]) begin
                r_rad <= '0;
            end else if (|rad_full[CW+3:CW]) begin
                r_rad <= '1;
            end else begin
                r_rad <= rad_full[CW-1:0];
            end
            // on the z axis the azimuth is defined as 0
            r_az <= (r_zf[T-2] || r_xz[T-2]) ? '0 : az_rnd[31 -: ANGLE_WIDTH];
            r_el <= r_zf[T-2] ? '0 : el_rnd[31 -: ANGLE_WIDTH];
        end
    end

    assign o_valid           = r_vld[T-1];
    assign o_radius          = r_rad;
    assign o_azimuth_angle   = signed'(r_az);
    assign o_elevation_angle = signed'(r_el);
    assign o_zero_vector     = r_zf[T-1];

endmodule
